[design/aes_pkg.sv]
package aes_pkg;

  localparam int ROUNDS = 10;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  // register map, index = paddr[4:3]
  typedef enum logic [1:0] {
    REG_KEY_LOW     = 2'd0,
    REG_KEY_HIGH    = 2'd1,
    REG_DECRYPT     = 2'd2,
    REG_BLOCK_COUNT = 2'd3
  } reg_idx_t;

  // key expander status seen by the datapath
  typedef struct packed {
    logic busy;
    blk_t last_key;
  } kx_status_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic byte_t rcon(input logic [3:0] r);
    case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_bytes(input blk_t s, input logic inv);
    blk_t t;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = inv ? INV_SBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic blk_t shift_rows(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = s[8*(4*((c+r)%4)+r) +: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic blk_t inv_shift_rows(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*((c+r)%4)+r) +: 8] = s[8*(4*c+r) +: 8];
      end
    end
    inv_shift_rows = t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t  t;
    byte_t a [4];
    byte_t d [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = s[8*(4*c+k) +: 8];
        d[k] = xtime(a[k]);
      end
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = d[r] ^ d[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    mix_columns = t;
  endfunction

  function automatic blk_t inv_mix_columns(input blk_t s);
    blk_t  t;
    byte_t a [4];
    byte_t m9 [4];
    byte_t m11 [4];
    byte_t m13 [4];
    byte_t m14 [4];
    byte_t x2;
    byte_t x4;
    byte_t x8;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = s[8*(4*c+k) +: 8];
        x2     = xtime(a[k]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[k]  = x8 ^ a[k];
        m11[k] = x8 ^ x2 ^ a[k];
        m13[k] = x8 ^ x4 ^ a[k];
        m14[k] = x8 ^ x4 ^ x2;
      end
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
      end
    end
    inv_mix_columns = t;
  endfunction

  // RotWord, SubWord and round constant on one word (byte 0 is the word's low byte)
  function automatic logic [31:0] key_core(input logic [31:0] w, input byte_t rc);
    key_core = {SBOX[w[7:0]], SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]] ^ rc};
  endfunction

  // round key r-1 -> r
  function automatic blk_t key_fwd(input blk_t k, input byte_t rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[31:0] ^ key_core(k[127:96], rc);
    n1 = k[63:32] ^ n0;
    n2 = k[95:64] ^ n1;
    n3 = k[127:96] ^ n2;
    key_fwd = {n3, n2, n1, n0};
  endfunction

  // round key r -> r-1, rc being the constant of round r
  function automatic blk_t key_bwd(input blk_t k, input byte_t rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[127:96] ^ k[95:64];
    p2 = k[95:64] ^ k[63:32];
    p1 = k[63:32] ^ k[31:0];
    p0 = k[31:0] ^ key_core(p3, rc);
    key_bwd = {p3, p2, p1, p0};
  endfunction

endpackage

[design/aes_stream_if.sv]
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  modport source (output valid, output data_low, output data_high, input ready);
  modport sink (input valid, input data_low, input data_high, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  logic        last_block;
  modport source (output valid, output result_low, output result_high, output last_block,
                  input ready);
  modport sink (input valid, input result_low, input result_high, input last_block,
                output ready);
endinterface

[design/aes_key_expand.sv]
module aes_key_expand (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  aes_pkg::blk_t       key,
  output aes_pkg::kx_status_t status
);

  logic          load;
  logic [3:0]    step;
  aes_pkg::blk_t w;

  // one key round per cycle, loaded from the key registers in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      load <= 1'b1;
      step <= 4'd0;
    end else if (start) begin
      load <= 1'b1;
      step <= 4'd0;
    end else if (load) begin
      load <= 1'b0;
      step <= 4'd1;
    end else if (step != 4'd0) begin
      step <= (step == 4'(aes_pkg::ROUNDS)) ? 4'd0 : step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w <= key;
    end else if (step != 4'd0) begin
      w <= aes_pkg::key_fwd(w, aes_pkg::rcon(step));
    end
  end

  assign status = {load | (step != 4'd0), w};

endmodule

[design/aes_round_pipe.sv]
module aes_round_pipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  aes_pkg::blk_t in_data,
  input  aes_pkg::blk_t first_key,
  input  aes_pkg::blk_t last_key,
  input  logic          in_dec,
  input  logic          in_last,
  input  logic          hold,
  output logic          out_valid,
  input  logic          out_ready,
  output aes_pkg::blk_t out_data,
  output logic          out_last
);

  localparam int N = aes_pkg::ROUNDS;

  logic          v    [0:N];
  logic          rdy  [0:N];
  aes_pkg::blk_t st   [0:N];
  aes_pkg::blk_t rk   [0:N];
  logic          dec  [0:N];
  logic          lst  [0:N];

  // a stage takes a beat when empty or when its own beat moves on
  assign rdy[N] = ~v[N] | out_ready;
  for (genvar j = 0; j < N; j++) begin : g_rdy
    assign rdy[j] = ~v[j] | rdy[j+1];
  end
  assign in_ready = rdy[0] & ~hold;

  // stage 0: initial key addition
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_valid & in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] & in_valid & in_ready) begin
      st[0]  <= in_data ^ (in_dec ? last_key : first_key);
      rk[0]  <= in_dec ? last_key : first_key;
      dec[0] <= in_dec;
      lst[0] <= in_last;
    end
  end

  // one round per stage, round key derived alongside
  for (genvar j = 1; j <= N; j++) begin : g_rnd
    aes_pkg::blk_t k_enc, k_dec, e_st, d_st;

    assign k_enc = aes_pkg::key_fwd(rk[j-1], aes_pkg::rcon(4'(j)));
    assign k_dec = aes_pkg::key_bwd(rk[j-1], aes_pkg::rcon(4'(N + 1 - j)));

    if (j < N) begin : g_mid
      assign e_st = aes_pkg::mix_columns(aes_pkg::shift_rows(
                      aes_pkg::sub_bytes(st[j-1], 1'b0))) ^ k_enc;
      assign d_st = aes_pkg::inv_mix_columns(aes_pkg::sub_bytes(
                      aes_pkg::inv_shift_rows(st[j-1]), 1'b1) ^ k_dec);
    end else begin : g_fin
      assign e_st = aes_pkg::shift_rows(aes_pkg::sub_bytes(st[j-1], 1'b0)) ^ k_enc;
      assign d_st = aes_pkg::sub_bytes(aes_pkg::inv_shift_rows(st[j-1]), 1'b1) ^ k_dec;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] & v[j-1]) begin
        st[j]  <= dec[j-1] ? d_st : e_st;
        rk[j]  <= dec[j-1] ? k_dec : k_enc;
        dec[j] <= dec[j-1];
        lst[j] <= lst[j-1];
      end
    end
  end

  assign out_valid = v[N];
  assign out_data  = st[N];
  assign out_last  = lst[N];

endmodule

[design/aes128_ecb_block_cipher.sv]
// AES-128 ECB cipher, one 128-bit block per beat, byte i of a block at bits 8i (low word
// bytes 0..7). Eleven register stages (initial key addition, then one AES round each, the
// round key computed next to the data); a new block may enter every cycle unless
// the output stalls or the key expander is busy. The direction is sampled per block.
// A write of either key register restarts the iterative key expander, which walks the
// schedule one round per cycle to find the last round key; input is held off while it
// runs, after such a write and after reset. Registers (APB, 64-bit, at 8*i): key_low,
// key_high, decrypt_mode, block_count; writing block_count starts a new job, and
// last_block marks block block_count-1 of each job.
module aes128_ecb_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  aes_in_if.sink      blk_in,
  aes_out_if.source   blk_out
);

  logic [63:0]         key_low;
  logic [63:0]         key_high;
  logic                decrypt_mode;
  logic [15:0]         block_count;
  logic [15:0]         block_index;
  aes_pkg::reg_idx_t   widx;
  logic                wr;
  logic                key_wr;
  logic                in_acc;
  logic                is_last;
  aes_pkg::kx_status_t kx;
  aes_pkg::blk_t       res;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign widx   = aes_pkg::reg_idx_t'(paddr[4:3]);
  assign key_wr = wr & ((widx == aes_pkg::REG_KEY_LOW) | (widx == aes_pkg::REG_KEY_HIGH));

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= 64'd0;
      key_high     <= 64'd0;
      decrypt_mode <= 1'b0;
      block_count  <= 16'd1;
    end else if (wr) begin
      case (widx)
        aes_pkg::REG_KEY_LOW:     key_low      <= pwdata;
        aes_pkg::REG_KEY_HIGH:    key_high     <= pwdata;
        aes_pkg::REG_DECRYPT:     decrypt_mode <= pwdata[0];
        aes_pkg::REG_BLOCK_COUNT: block_count  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      aes_pkg::REG_KEY_LOW:     prdata = key_low;
      aes_pkg::REG_KEY_HIGH:    prdata = key_high;
      aes_pkg::REG_DECRYPT:     prdata = {63'd0, decrypt_mode};
      aes_pkg::REG_BLOCK_COUNT: prdata = {48'd0, block_count};
      default:                  prdata = 64'd0;
    endcase
  end

  // job block counter
  assign in_acc  = blk_in.valid & blk_in.ready;
  assign is_last = (block_index == block_count - 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_index <= 16'd0;
    end else if (wr & (widx == aes_pkg::REG_BLOCK_COUNT)) begin
      block_index <= 16'd0;
    end else if (in_acc) begin
      block_index <= is_last ? 16'd0 : block_index + 16'd1;
    end
  end

  aes_key_expand u_kx (
    .clk    (clk),
    .rst    (rst),
    .start  (key_wr),
    .key    ({key_high, key_low}),
    .status (kx)
  );

  aes_round_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .in_data   ({blk_in.data_high, blk_in.data_low}),
    .first_key ({key_high, key_low}),
    .last_key  (kx.last_key),
    .in_dec    (decrypt_mode),
    .in_last   (is_last),
    .hold      (kx.busy),
    .out_valid (blk_out.valid),
    .out_ready (blk_out.ready),
    .out_data  (res),
    .out_last  (blk_out.last_block)
  );

  assign blk_out.result_low  = res[63:0];
  assign blk_out.result_high = res[127:64];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !kx.busy) else $error("block accepted during key expansion");

  a_key_wr_busy: assert property (@(posedge clk) disable iff (rst)
    key_wr |=> kx.busy) else $error("key write did not start expansion");

  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    wr && widx == aes_pkg::REG_BLOCK_COUNT |=> block_index == 16'd0)
    else $error("block counter not cleared on new job");

endmodule
